// ===== sv/isometric_tile_pick_and_update_unit_defines.svh =====
// Assertion macros for the isometric tile pick and update unit.
`ifndef ISOMETRIC_TILE_PICK_AND_UPDATE_UNIT_DEFINES_SVH
`define ISOMETRIC_TILE_PICK_AND_UPDATE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every edge out of reset.
`define ITPU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ITPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ITPU_ASSERT_NOW(label, ante, cons, msg)
`define ITPU_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/itpu_pkg.sv =====
// Shared types and constants of the isometric tile pick and update unit.
`timescale 1ns / 1ps
package itpu_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int IDX_W       = 10;
  localparam int PT_W        = 16;
  localparam int FIELD_W     = 8;
  localparam int ENTRY_W     = 2 * FIELD_W;

  localparam logic [FIELD_W-1:0] RESET_DRAW_ID = 8'd7;
  localparam logic [FIELD_W-1:0] RESET_OPTION  = 8'd0;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture item, restart scan counters
    logic step;      // advance scan by one tile
    logic clr_wr;    // write reset entry, advance clear pointer
    logic capture;   // latch scan outcome into hold registers
    logic upd_wr;    // write new draw id / option at hit tile
    logic res_load;  // move hold registers to output register
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic hit;        // compare stage holds a tile containing the point
    logic s1_valid;   // compare stage holds a tile
    logic s1_last;    // compare stage tile is the last one
    logic idx0_last;  // scan counter sits on the last tile
    logic clr_last;   // clear pointer on the last entry
    logic out_busy;   // output register full and stalled
  } ctl_sts_t;

endpackage

// ===== sv/itpu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module itpu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/itpu_ctrl.sv =====
// Sequencer: clear pass, item intake, tile scan and result handoff.
`timescale 1ns / 1ps
module itpu_ctrl import itpu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   tail_r, tail_nxt;   // last tile already issued

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    tail_nxt  = tail_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          tail_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = !tail_r;
        if (cmd.step && sts.idx0_last) begin
          tail_nxt = 1'b1;
        end
        if (sts.hit) begin
          cmd.upd_wr  = 1'b1;
          cmd.capture = 1'b1;
          state_nxt   = ST_DONE;
        end else if (sts.s1_valid && sts.s1_last) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      tail_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tail_r  <= tail_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// ===== sv/itpu_dp.sv =====
// Datapath: diamond test pipeline, scan counters, tile store, result registers.
`timescale 1ns / 1ps
module itpu_dp import itpu_pkg::*; #(
  parameter int TILE_WIDTH  = 128,
  parameter int TILE_HEIGHT = 64,
  parameter int COLUMNS     = 32,
  parameter int ROWS        = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [PT_W-1:0]   in_point_x,
  input  logic signed [PT_W-1:0]   in_point_y,
  input  logic [FIELD_W-1:0]       in_new_draw_id,
  input  logic [FIELD_W-1:0]       in_new_option,
  input  ctl_cmd_t                 cmd,
  output ctl_sts_t                 sts,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_hit,
  output logic [IDX_W-1:0]         out_tile_index
);

  localparam int TOTAL_RAW = ROWS * COLUMNS;
  localparam int TOTAL     = (TOTAL_RAW > STORE_DEPTH) ? STORE_DEPTH : TOTAL_RAW;
  localparam int COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  // Doubled-coordinate steps, pre-scaled by the opposite tile size.
  localparam int HSTEP  = 2 * TILE_HEIGHT * TILE_WIDTH;
  localparam int HOFF   = 2 * TILE_HEIGHT * (TILE_WIDTH / 2);
  localparam int VSTEP  = 2 * TILE_WIDTH * (TILE_HEIGHT / 2);
  localparam int THRESH = TILE_WIDTH * TILE_HEIGHT;
  localparam int A_MAX  = TILE_HEIGHT * 65536 + HSTEP * COLUMNS + HOFF;
  localparam int B_MAX  = TILE_WIDTH * 65536 + VSTEP * ROWS;
  localparam int ACC_W  = 1 + $clog2(((A_MAX > B_MAX) ? A_MAX : B_MAX) + 1);

  localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(TOTAL - 1);
  localparam logic [COL_W-1:0]        LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic signed [ACC_W-1:0] HMUL     = ACC_W'(2 * TILE_HEIGHT);
  localparam logic signed [ACC_W-1:0] WMUL     = ACC_W'(2 * TILE_WIDTH);

  // item registers
  logic signed [ACC_W-1:0] hpx_r, wpy_r;
  logic [FIELD_W-1:0]      did_r, opt_r;
  // scan counters
  logic signed [ACC_W-1:0] hcx_r, wcy_r;
  logic [COL_W-1:0]        col_r;
  logic                    odd_r;
  logic [IDX_W-1:0]        idx0_r;
  // compare stage
  logic [ACC_W-2:0]        abs_a_r, abs_b_r;
  logic [IDX_W-1:0]        idx1_r;
  logic                    s1_valid_r;
  // hold and output
  logic                    hold_hit_r;
  logic [IDX_W-1:0]        hold_idx_r;
  logic                    out_valid_r, out_hit_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic [IDX_W-1:0]        clr_ptr_r;

  logic signed [ACC_W-1:0] px_ext, py_ext, diff_a, diff_b;
  logic [ACC_W-1:0]        l1_sum;
  logic                    hit;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_addr;
  logic [ENTRY_W-1:0]      mem_wdata;

  assign px_ext = ACC_W'(in_point_x);
  assign py_ext = ACC_W'(in_point_y);
  assign diff_a = hpx_r - hcx_r;
  assign diff_b = wpy_r - wcy_r;
  assign l1_sum = {1'b0, abs_a_r} + {1'b0, abs_b_r};
  assign hit    = s1_valid_r && (l1_sum <= ACC_W'(THRESH));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hpx_r <= px_ext * HMUL;
      wpy_r <= py_ext * WMUL;
      did_r <= in_new_draw_id;
      opt_r <= in_new_option;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hcx_r  <= '0;
      wcy_r  <= '0;
      col_r  <= '0;
      odd_r  <= 1'b0;
      idx0_r <= '0;
    end else if (cmd.step) begin
      idx0_r <= idx0_r + 1'b1;
      if (col_r == LAST_COL) begin
        col_r <= '0;
        odd_r <= !odd_r;
        hcx_r <= odd_r ? '0 : ACC_W'(HOFF);
        wcy_r <= wcy_r + ACC_W'(VSTEP);
      end else begin
        col_r <= col_r + 1'b1;
        hcx_r <= hcx_r + ACC_W'(HSTEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    abs_a_r <= (ACC_W-1)'(diff_a[ACC_W-1] ? -diff_a : diff_a);
    abs_b_r <= (ACC_W-1)'(diff_b[ACC_W-1] ? -diff_b : diff_b);
    idx1_r  <= idx0_r;
    if (cmd.capture) begin
      hold_hit_r <= hit;
      hold_idx_r <= hit ? idx1_r : '0;
    end
    if (cmd.res_load) begin
      out_hit_r <= hold_hit_r;
      out_idx_r <= hold_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      clr_ptr_r   <= '0;
    end else begin
      s1_valid_r <= cmd.step;
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.clr_wr) begin
        clr_ptr_r <= clr_ptr_r + 1'b1;
      end
    end
  end

  // Tile store: {draw id, option} per tile
  assign mem_we    = cmd.clr_wr || cmd.upd_wr;
  assign mem_addr  = cmd.clr_wr ? clr_ptr_r : idx1_r;
  assign mem_wdata = cmd.clr_wr ? {RESET_DRAW_ID, RESET_OPTION} : {did_r, opt_r};

  itpu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_tile_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_addr),
    .wr_data (mem_wdata),
    .rd_en   (1'b0),
    .rd_addr ('0),
    .rd_data ()
  );

  always_comb begin
    sts           = '0;
    sts.hit       = hit;
    sts.s1_valid  = s1_valid_r;
    sts.s1_last   = (idx1_r == LAST_IDX);
    sts.idx0_last = (idx0_r == LAST_IDX);
    sts.clr_last  = (clr_ptr_r == IDX_W'(STORE_DEPTH - 1));
    sts.out_busy  = out_valid_r && out_stall;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_tile_index = out_idx_r;

endmodule

// ===== sv/isometric_tile_pick_and_update_unit.sv =====
// Isometric tile pick and update unit: top level.
// Scan: one tile tested per cycle, in index order, up to the first hit;
//   with no hit, all ROWS*COLUMNS tiles (capped at 1024 tiles) are tested.
// Intake: a new item is taken only after the last result is handed off;
//   the single diamond-test pipeline scans tiles for one item at a time.
// Reset: synchronous, active low; a clear of all 1024 entries follows, in_stall high.
`timescale 1ns / 1ps
`include "isometric_tile_pick_and_update_unit_defines.svh"
module isometric_tile_pick_and_update_unit import itpu_pkg::*; #(
  parameter int TILE_WIDTH  = 128,
  parameter int TILE_HEIGHT = 64,
  parameter int COLUMNS     = 32,
  parameter int ROWS        = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input items
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [PT_W-1:0] in_point_x,
  input  logic signed [PT_W-1:0] in_point_y,
  input  logic [FIELD_W-1:0]     in_new_draw_id,
  input  logic [FIELD_W-1:0]     in_new_option,
  // result items
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_hit,
  output logic [IDX_W-1:0]       out_tile_index
);

  // Controller and datapath talk only through these two structs.
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Controller: clear pass after reset, then idle / scan / handoff.
  // The input side is open only in idle, so a new item can be taken while
  // an earlier result still sits stalled in the output register.
  itpu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: the test is h*|dx| + w*|dy| <= w*h in doubled coordinates.
  // The point terms are scaled once at intake; the tile-center terms are
  // stepped incrementally by the scan counters, so no multiply per tile.
  itpu_dp #(
    .TILE_WIDTH  (TILE_WIDTH),
    .TILE_HEIGHT (TILE_HEIGHT),
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_new_draw_id (in_new_draw_id),
    .in_new_option  (in_new_option),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_tile_index (out_tile_index)
  );

  // A store update happens only on a genuine hit that is also being recorded.
  `ITPU_ASSERT_NOW(a_upd_on_hit, cmd.upd_wr, cmd.capture && sts.hit, "store write without hit")
  // A miss reports index zero.
  `ITPU_ASSERT_NOW(a_miss_idx, out_valid && !out_hit, out_tile_index == '0, "miss with index")
  // Handing a result over reopens the input side next cycle.
  `ITPU_ASSERT_NEXT(a_reopen, cmd.res_load, !in_stall, "input not reopened after handoff")
  // A taken result with nothing new behind it drops valid.
  `ITPU_ASSERT_NEXT(a_out_drop, out_valid && !out_stall && !cmd.res_load, !out_valid,
                    "result item repeated")

endmodule

// ===== tb/tb_isometric_tile_pick_and_update_unit.sv =====
// Self-checking testbench for the isometric tile pick and update unit.
`timescale 1ns / 1ps
module tb_isometric_tile_pick_and_update_unit;
  import itpu_pkg::*;

  // Grid geometry, kept equal to the block's defaults.
  localparam int TILE_WIDTH  = 128;
  localparam int TILE_HEIGHT = 64;
  localparam int COLUMNS     = 32;
  localparam int ROWS        = 32;

  localparam int RANDOM_CLICKS  = 580;
  localparam int DRAIN_CYCLES   = 1100;  // run-out after the last result is checked
  localparam int PRESSURE_AFTER = 30;    // results seen before the long output hold
  localparam int HOLD_CYCLES    = 4000;
  localparam int STEADY_LO      = 250;   // item window with no idling on either side
  localparam int STEADY_HI      = 350;
  localparam int IDLE_PCT       = 33;

  // One pointer click: the input item.
  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic [FIELD_W-1:0]     draw_id;
    logic [FIELD_W-1:0]     option;
  } click_t;

  // Outcome of one scan: the result item.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] index;
  } pick_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [PT_W-1:0] in_point_x = '0;
  logic signed [PT_W-1:0] in_point_y = '0;
  logic [FIELD_W-1:0]     in_new_draw_id = '0;
  logic [FIELD_W-1:0]     in_new_option = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_hit;
  logic [IDX_W-1:0]       out_tile_index;

  click_t click_q[$];   // clicks not yet offered
  pick_t  pick_q[$];    // predicted picks, oldest first

  // Mirror of the tile table. Not visible at the ports, but kept in step with
  // the block so the predictor holds the same state it does.
  logic [FIELD_W-1:0] draw_tbl[STORE_DEPTH];
  logic [FIELD_W-1:0] option_tbl[STORE_DEPTH];

  int clicks_taken = 0;
  int results_seen = 0;
  int errors       = 0;
  int total_clicks;
  int hold_left    = 0;
  logic hold_done  = 1'b0;

  isometric_tile_pick_and_update_unit #(
    .TILE_WIDTH (TILE_WIDTH),
    .TILE_HEIGHT(TILE_HEIGHT),
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_new_draw_id(in_new_draw_id),
    .in_new_option (in_new_option),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_tile_index(out_tile_index)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // First tile in index order whose diamond holds the point. Coordinates are
  // doubled so the half tile sizes stay whole; edges and corners count as in.
  function automatic pick_t locate_tile(input logic signed [PT_W-1:0] x,
                                        input logic signed [PT_W-1:0] y);
    pick_t  res;
    longint w, h, px2, py2, dx, dy, r, c, n, k;
    w   = TILE_WIDTH;
    h   = TILE_HEIGHT;
    px2 = 2 * longint'(x);
    py2 = 2 * longint'(y);
    n   = longint'(ROWS) * COLUMNS;
    if (n > STORE_DEPTH) n = STORE_DEPTH;
    res = '0;
    for (k = 0; k < n; k++) begin
      r  = k / COLUMNS;
      c  = k % COLUMNS;
      dx = px2 - 2 * (w * c + (r % 2) * (w / 2));
      dy = py2 - 2 * ((h / 2) * r);
      if (h * dx + w * (dy - h) <= 0 && h * (dx - w) - w * dy <= 0 &&
          -h * dx - w * (dy + h) <= 0 && -h * (dx + w) + w * dy <= 0) begin
        res.hit   = 1'b1;
        res.index = IDX_W'(k);
        return res;
      end
    end
    return res;
  endfunction

  task automatic queue_click(input int x, input int y, input int draw_id, input int option);
    click_t cl;
    cl.x       = PT_W'(x);
    cl.y       = PT_W'(y);
    cl.draw_id = FIELD_W'(draw_id);
    cl.option  = FIELD_W'(option);
    click_q.push_back(cl);
  endtask

  // Sender. Once valid goes up it stays up with a steady payload until the
  // block takes the item; a new item is loaded only after the last was taken.
  always @(posedge clk) begin : drive
    click_t nxt;
    pick_t  p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        // Taken: predict the pick and apply the table update it causes.
        p = locate_tile(in_point_x, in_point_y);
        if (p.hit) begin
          draw_tbl[p.index]   = in_new_draw_id;
          option_tbl[p.index] = in_new_option;
        end
        pick_q.push_back(p);
        clicks_taken <= clicks_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (click_q.size() > 0 &&
            ((clicks_taken >= STEADY_LO && clicks_taken < STEADY_HI) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = click_q.pop_front();
          in_valid       <= 1'b1;
          in_point_x     <= nxt.x;
          in_point_y     <= nxt.y;
          in_new_draw_id <= nxt.draw_id;
          in_new_option  <= nxt.option;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall. After the directed clicks it holds off once for a long
  // stretch so the result register fills and the block backs up its input;
  // otherwise it stalls at random, with a quiet window in the middle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (!hold_done && results_seen >= PRESSURE_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (results_seen >= STEADY_LO && results_seen < STEADY_HI) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Result checker: each taken result against the oldest prediction.
  always @(posedge clk) begin : check
    pick_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pick_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got hit %0b index %0d",
                 $time, out_hit, out_tile_index);
        errors++;
      end else begin
        want = pick_q.pop_front();
        if (out_hit !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b, got %0b", $time, want.hit, out_hit);
          errors++;
        end
        if (out_tile_index !== want.index) begin
          $display("%0t: tile_index mismatch, expected %0d, got %0d",
                   $time, want.index, out_tile_index);
          errors++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int x, y, k, r, c, cx, cy, mode, corner;
    foreach (draw_tbl[i]) begin
      draw_tbl[i]   = RESET_DRAW_ID;
      option_tbl[i] = RESET_OPTION;
    end

    // Directed: centers, all four corners of tile 0, a shared edge, points
    // just outside the grid, the last tile and the extremes of the fields.
    queue_click(0, 0, 0, 0);
    queue_click(0, -32, 255, 255);
    queue_click(-64, 0, 8'hAA, 8'h55);
    queue_click(64, 0, 8'h55, 8'hAA);      // corner shared by three tiles
    queue_click(0, 32, 1, 128);            // bottom of tile 0, top of row 2
    queue_click(32, 16, 2, 64);            // edge shared with row 1
    queue_click(64, 32, 4, 32);
    queue_click(-65, 0, 8, 16);
    queue_click(0, -33, 16, 8);
    queue_click(4032, 992, 32, 4);
    queue_click(4096, 992, 64, 2);
    queue_click(4097, 992, 128, 1);
    queue_click(-32768, -32768, 255, 0);
    queue_click(32767, 32767, 0, 255);
    queue_click(-32768, 32767, 8'h0F, 8'hF0);
    queue_click(32767, -32768, 8'hF0, 8'h0F);
    queue_click(-1, -1, 3, 3);
    queue_click(128, 0, 9, 9);
    queue_click(3968, 960, 10, 10);
    queue_click(100, 40, 11, 11);
    queue_click(0, 0, 12, 12);             // repick of an updated tile

    // Random: mostly points over the grid, some on corners and edge middles
    // of a random tile, the rest anywhere in the 16-bit range.
    repeat (RANDOM_CLICKS) begin
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        x = $urandom_range(0, 65535);
        y = $urandom_range(0, 65535);
      end else if (mode < 4) begin
        k  = $urandom_range(0, ROWS * COLUMNS - 1);
        r  = k / COLUMNS;
        c  = k % COLUMNS;
        cx = TILE_WIDTH * c + (r % 2) * (TILE_WIDTH / 2);
        cy = (TILE_HEIGHT / 2) * r;
        corner = $urandom_range(0, 7);
        case (corner)
          0: begin x = cx - TILE_WIDTH / 2; y = cy; end
          1: begin x = cx + TILE_WIDTH / 2; y = cy; end
          2: begin x = cx; y = cy - TILE_HEIGHT / 2; end
          3: begin x = cx; y = cy + TILE_HEIGHT / 2; end
          4: begin x = cx - TILE_WIDTH / 4; y = cy - TILE_HEIGHT / 4; end
          5: begin x = cx + TILE_WIDTH / 4; y = cy - TILE_HEIGHT / 4; end
          6: begin x = cx - TILE_WIDTH / 4; y = cy + TILE_HEIGHT / 4; end
          default: begin x = cx + TILE_WIDTH / 4; y = cy + TILE_HEIGHT / 4; end
        endcase
      end else begin
        x = $urandom_range(0, TILE_WIDTH * COLUMNS + TILE_WIDTH + 4) - TILE_WIDTH / 2;
        y = $urandom_range(0, (TILE_HEIGHT / 2) * ROWS + TILE_HEIGHT) - TILE_HEIGHT / 2;
      end
      queue_click(x, y, $urandom_range(0, 255), $urandom_range(0, 255));
    end
    total_clicks = click_q.size();

    // Hold reset, then release it; the block then runs its clearing pass.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (clicks_taken < total_clicks || pick_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #15_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== isometric_tile_pick_and_update_unit.f =====
+incdir+sv
sv/itpu_pkg.sv
sv/itpu_ram.sv
sv/itpu_ctrl.sv
sv/itpu_dp.sv
sv/isometric_tile_pick_and_update_unit.sv
tb/tb_isometric_tile_pick_and_update_unit.sv
